// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file rhh_checker.sv.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Invariant checked at every clock edge outside reset.
`define RHH_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rhh invariant violated");
// Implication into the following cycle.
`define RHH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhh sequence violated");
`endif

// ----- rtl/rhh_pkg.sv -----
// Package for the Robin Hood hash table: defaults, codes and state type.
// No dependencies.
`default_nettype none
package rhh_pkg;
  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int CFG_AW          = 3;
  localparam logic [3:0] MAX_KEY_LEN_RST = 4'd8;

  localparam logic [0:0] REG_MAX_KEY_LEN = 1'b0;

  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_INS_ABSENT = 2'd1;
  localparam logic [1:0] REQ_FIND       = 2'd2;
  localparam logic [1:0] REQ_REMOVE     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_H1, S_H2, S_H3, S_LK_RD, S_LK_CHK, S_DECIDE,
    S_PL_RD, S_PL_CHK, S_RM_RD, S_RM_CHK, S_RM_END, S_RESP
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/robin_hood_hash_table_core.sv -----
// Robin Hood open-addressing hash table, linear probing, backward-shift remove.
// One request is handled at a time. After reset a clearing pass writes every slot while
// in_stall is high. A request then computes its home slot, probes slots by lookup (up to
// max_probe+1 slots for find, remove and insert-if-absent), walks slots for insert or for
// the backward shift with a read state and a check state per slot, then decides and returns
// the result; all slot traffic goes through one single-port memory. Depends on rhh_pkg.
`default_nettype none
module robin_hood_hash_table_core #(
  parameter int TABLE_SLOTS = rhh_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = rhh_pkg::KEY_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic [31:0]               in_hash,
  input  wire logic [63:0]               in_key_bytes,
  input  wire logic [3:0]                in_key_len,
  input  wire logic [31:0]               in_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     out_status,
  output logic [31:0]                    out_found_value,
  output logic [10:0]                    out_entry_count,
  output logic [9:0]                     out_max_probe,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [rhh_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import rhh_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = IW + 1;
  localparam int MW = 1 + IW + 32 + 4 + 64 + 32;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

  state_t state_r, state_nxt;

  logic [3:0]    max_key_len_r;
  logic [1:0]    req_r;
  logic [31:0]   car_hash_r;
  logic [63:0]   car_key_r;
  logic [3:0]    car_len_r;
  logic [31:0]   car_val_r;
  logic [IW-1:0] car_dist_r;
  logic [31:0]   q_r, rem_r;
  logic [IW-1:0] ptr_r, prev_r, home_r;
  logic [CW-1:0] cnt_r, scan_r, count_r;
  logic [IW-1:0] maxd_r;
  logic          found_r;
  logic [31:0]   fval_r;
  logic [2:0]    res_status_r;
  logic [31:0]   res_fval_r;

  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [MW-1:0] mem_wdata, mem_rdata;

  logic          rd_valid;
  logic [IW-1:0] rd_dist;
  logic [31:0]   rd_val, rd_hash;
  logic [3:0]    rd_len;
  logic [63:0]   rd_key;
  logic          rd_match, rm_stop, pl_swap, out_free;
  logic [IW-1:0] ptr_inc, pl_dist_nxt;
  logic [63:0]   key_masked;
  logic [63:0]   q_prod;
  logic [31:0]   rem_fix;

  rhh_slot_ram #(.DEPTH(TABLE_SLOTS), .WIDTH(MW)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  assign rd_hash  = mem_rdata[31:0];
  assign rd_key   = mem_rdata[95:32];
  assign rd_len   = mem_rdata[99:96];
  assign rd_val   = mem_rdata[131:100];
  assign rd_dist  = mem_rdata[132 +: IW];
  assign rd_valid = mem_rdata[MW-1];

  assign rd_match = rd_valid && rd_len == car_len_r && rd_hash == car_hash_r &&
                    rd_key == car_key_r;
  assign rm_stop  = !rd_valid || rd_dist == '0;
  assign pl_swap  = car_dist_r > rd_dist;
  assign pl_dist_nxt = (pl_swap ? rd_dist : car_dist_r) + 1'b1;
  assign ptr_inc  = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign q_prod   = {32'd0, car_hash_r} * {32'd0, RECIP};
  assign rem_fix  = (rem_r >= 32'(TABLE_SLOTS)) ? rem_r - 32'(TABLE_SLOTS) : rem_r;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      key_masked[8*b +: 8] = (4'(b) < in_key_len && b < KEY_BYTES) ?
                             in_key_bytes[8*b +: 8] : 8'd0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:    if (ptr_r == LAST) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_H1;
      S_H1:     state_nxt = S_H2;
      S_H2:     state_nxt = S_H3;
      S_H3:     state_nxt = (req_r == REQ_INSERT) ? S_DECIDE : S_LK_RD;
      S_LK_RD:  state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        if (rd_match || cnt_r + 1'b1 >= scan_r) state_nxt = S_DECIDE;
        else state_nxt = S_LK_RD;
      end
      S_DECIDE: begin
        unique case (req_r)
          REQ_FIND: state_nxt = S_RESP;
          REQ_REMOVE: state_nxt = found_r ? S_RM_RD : S_RESP;
          default: begin
            if ((req_r == REQ_INS_ABSENT && found_r) || car_len_r > max_key_len_r ||
                car_len_r > 4'(KEY_BYTES) || count_r >= CW'(TABLE_SLOTS)) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_PL_RD;
            end
          end
        endcase
      end
      S_PL_RD:  state_nxt = S_PL_CHK;
      S_PL_CHK: state_nxt = rd_valid ? S_PL_RD : S_RESP;
      S_RM_RD:  state_nxt = S_RM_CHK;
      S_RM_CHK: begin
        if (rm_stop || cnt_r + 1'b1 == CW'(TABLE_SLOTS)) state_nxt = S_RM_END;
        else state_nxt = S_RM_RD;
      end
      S_RM_END: state_nxt = S_RESP;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ptr_r;
    mem_wdata = '0;
    in_stall  = state_r != S_IDLE;
    unique case (state_r)
      S_CLR: mem_we = 1'b1;
      S_PL_CHK: begin
        mem_we    = !rd_valid || pl_swap;
        mem_wdata = {1'b1, car_dist_r, car_val_r, car_len_r, car_key_r, car_hash_r};
      end
      S_RM_CHK: begin
        mem_we    = !rm_stop;
        mem_addr  = prev_r;
        mem_wdata = {1'b1, rd_dist - 1'b1, rd_val, rd_len, rd_key, rd_hash};
      end
      S_RM_END: begin
        mem_we   = 1'b1;
        mem_addr = prev_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      ptr_r         <= '0;
      count_r       <= '0;
      maxd_r        <= '0;
      max_key_len_r <= MAX_KEY_LEN_RST;
      out_valid     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_MAX_KEY_LEN) begin
        max_key_len_r <= cfg_pwdata[3:0];
      end
      if (out_valid && !out_stall && state_r != S_RESP) out_valid <= 1'b0;
      case (state_r)
        S_CLR: ptr_r <= ptr_inc;
        S_IDLE: begin
          if (in_valid) begin
            req_r      <= in_req_type;
            car_hash_r <= in_hash;
            car_key_r  <= key_masked;
            car_len_r  <= in_key_len;
            car_val_r  <= in_value;
            car_dist_r <= '0;
            found_r    <= 1'b0;
            fval_r     <= '0;
            cnt_r      <= '0;
            scan_r     <= CW'(maxd_r) + 1'b1;
          end
        end
        S_H1: q_r <= q_prod[63:32];
        S_H2: rem_r <= car_hash_r - 32'({32'd0, q_r} * 64'(TABLE_SLOTS));
        S_H3: begin
          home_r <= rem_fix[IW-1:0];
          ptr_r  <= rem_fix[IW-1:0];
        end
        S_LK_CHK: begin
          if (rd_match) begin
            found_r <= 1'b1;
            fval_r  <= rd_val;
            prev_r  <= ptr_r;
          end
          ptr_r <= ptr_inc;
          cnt_r <= cnt_r + 1'b1;
        end
        S_DECIDE: begin
          unique case (req_r)
            REQ_FIND: begin
              res_status_r <= found_r ? ST_OK : ST_NOT_FOUND;
              res_fval_r   <= found_r ? fval_r : '0;
            end
            REQ_REMOVE: begin
              res_status_r <= found_r ? ST_OK : ST_NOT_FOUND;
              res_fval_r   <= '0;
              ptr_r        <= (prev_r == LAST) ? '0 : prev_r + 1'b1;
              cnt_r        <= '0;
            end
            default: begin
              res_fval_r <= '0;
              ptr_r      <= home_r;
              if (req_r == REQ_INS_ABSENT && found_r) res_status_r <= ST_DUPLICATE;
              else if (car_len_r > max_key_len_r || car_len_r > 4'(KEY_BYTES))
                res_status_r <= ST_TOO_LONG;
              else if (count_r >= CW'(TABLE_SLOTS)) res_status_r <= ST_FULL;
              else res_status_r <= ST_OK;
            end
          endcase
        end
        S_PL_CHK: begin
          if (!rd_valid) begin
            count_r <= count_r + 1'b1;
          end else begin
            if (pl_swap) begin
              car_hash_r <= rd_hash;
              car_key_r  <= rd_key;
              car_len_r  <= rd_len;
              car_val_r  <= rd_val;
            end
            car_dist_r <= pl_dist_nxt;
            if (pl_dist_nxt > maxd_r) maxd_r <= pl_dist_nxt;
            ptr_r <= ptr_inc;
          end
        end
        S_RM_CHK: begin
          if (!rm_stop) begin
            prev_r <= ptr_r;
            ptr_r  <= ptr_inc;
            cnt_r  <= cnt_r + 1'b1;
          end
        end
        S_RM_END: if (count_r != '0) count_r <= count_r - 1'b1;
        S_RESP: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_status      <= res_status_r;
            out_found_value <= res_fval_r;
            out_entry_count <= 11'(32'(count_r));
            out_max_probe   <= 10'(32'(maxd_r));
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_MAX_KEY_LEN) ?
                      {28'd0, max_key_len_r} : 32'd0;
endmodule
`default_nettype wire

// ----- rtl/rhh_slot_ram.sv -----
// Single-port slot memory with registered read data.
// Depends on nothing; widths come from the top level.
`default_nettype none
module rhh_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/rhh_checker.sv -----
// Port-level checker for the hash table core, bound to the top level.
// Depends on rhh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rhh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_found_value
);
  import rhh_pkg::*;

  `RHH_ASSERT_ALWAYS(a_status_code, !out_valid || out_status <= ST_FULL)
  `RHH_ASSERT_ALWAYS(a_value_only_ok, !out_valid || out_status == ST_OK || out_found_value == '0)
  `RHH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RHH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))
endmodule

bind robin_hood_hash_table_core rhh_checker u_rhh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_found_value(out_found_value)
);
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for robin_hood_hash_table_core: a directed table, then random requests over
// clustered hashes at several max_key_len settings; a built-in Robin Hood table model
// predicts each untyped row's result. Depends on rhh_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import rhh_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int LIMIT = 4000000;
  localparam int POOL = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [10:0] entry_count;
    logic [9:0]  max_probe;
  } rsp_t;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] hash;
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] value;
    bit          typed;
    rsp_t        rsp;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] in_req_type;
  logic [31:0] in_hash, in_value;
  logic [63:0] in_key_bytes;
  logic [3:0] in_key_len;
  logic [2:0] out_status;
  logic [31:0] out_found_value;
  logic [10:0] out_entry_count;
  logic [9:0] out_max_probe;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  robin_hood_hash_table_core uut (.*);

  // table model
  bit          tbl_valid [SLOTS];
  logic [31:0] tbl_hash  [SLOTS];
  logic [63:0] tbl_key   [SLOTS];
  logic [3:0]  tbl_len   [SLOTS];
  logic [31:0] tbl_value [SLOTS];
  int          tbl_dist  [SLOTS];
  int occupied, max_dist;
  logic [3:0] key_limit;

  rsp_t pending_results[$];
  row_t cur_row;
  int errors, accepted, cycles;
  bit quiet;

  function automatic logic [63:0] len_mask(logic [3:0] len);
    if (len >= 8) return '1;
    return (64'd1 << (8 * len)) - 1;
  endfunction

  function automatic int find_slot(logic [31:0] h, logic [63:0] k, logic [3:0] l);
    int s, scan;
    s = h % SLOTS;
    scan = (max_dist + 1 > SLOTS) ? SLOTS : max_dist + 1;
    for (int i = 0; i < scan; i++) begin
      if (tbl_valid[s] && tbl_len[s] == l && tbl_hash[s] == h && tbl_key[s] == k) return s;
      s = (s + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic void place_entry(logic [31:0] h, logic [63:0] k, logic [3:0] l,
                                      logic [31:0] v);
    int s, d, td, i;
    logic [31:0] th, tv;
    logic [63:0] tk;
    logic [3:0] tl;
    s = h % SLOTS;
    d = 0;
    i = 0;
    while (i < SLOTS && tbl_valid[s]) begin
      if (d > tbl_dist[s]) begin
        th = tbl_hash[s]; tv = tbl_value[s]; td = tbl_dist[s]; tk = tbl_key[s]; tl = tbl_len[s];
        tbl_hash[s] = h; tbl_value[s] = v; tbl_dist[s] = d; tbl_key[s] = k; tbl_len[s] = l;
        h = th; v = tv; d = td; k = tk; l = tl;
      end
      d++;
      s = (s + 1) % SLOTS;
      i++;
      if (d > max_dist) max_dist = d;
    end
    tbl_valid[s] = 1;
    tbl_hash[s] = h; tbl_key[s] = k; tbl_len[s] = l; tbl_value[s] = v; tbl_dist[s] = d;
  endfunction

  function automatic void shift_out(int s);
    int prev, cur;
    prev = s;
    cur = (s + 1) % SLOTS;
    tbl_valid[s] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[cur] || tbl_dist[cur] == 0) break;
      tbl_valid[prev] = 1;
      tbl_hash[prev] = tbl_hash[cur];
      tbl_key[prev] = tbl_key[cur];
      tbl_len[prev] = tbl_len[cur];
      tbl_value[prev] = tbl_value[cur];
      tbl_dist[prev] = tbl_dist[cur] - 1;
      tbl_valid[cur] = 0;
      prev = cur;
      cur = (cur + 1) % SLOTS;
    end
  endfunction

  function automatic rsp_t predict_request(logic [1:0] req, logic [31:0] h, logic [63:0] kin,
                                           logic [3:0] l, logic [31:0] v);
    rsp_t r;
    int pos;
    logic [63:0] k;
    k = kin & len_mask(l);
    r = '0;
    r.status = ST_OK;
    if (req == REQ_FIND) begin
      pos = find_slot(h, k, l);
      if (pos < 0) r.status = ST_NOT_FOUND;
      else r.found_value = tbl_value[pos];
    end else if (req == REQ_REMOVE) begin
      pos = find_slot(h, k, l);
      if (pos < 0) r.status = ST_NOT_FOUND;
      else begin
        shift_out(pos);
        if (occupied > 0) occupied--;
      end
    end else if (req == REQ_INS_ABSENT && find_slot(h, k, l) >= 0) r.status = ST_DUPLICATE;
    else if (l > key_limit || l > KEY_BYTES_DEF) r.status = ST_TOO_LONG;
    else if (occupied >= SLOTS) r.status = ST_FULL;
    else begin
      place_entry(h, k, l, v);
      occupied++;
    end
    r.entry_count = 11'(occupied);
    r.max_probe = 10'(max_dist);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_t want, r;
    cycles++;
    if (cycles > LIMIT) begin
      $display("[robin_hood_hash_table_core] ERROR");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      r = predict_request(in_req_type, in_hash, in_key_bytes, in_key_len, in_value);
      pending_results.push_back(cur_row.typed ? cur_row.rsp : r);
      accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected transaction", 32'd0, 32'd1);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report("status", want.status, out_status);
        if (out_found_value !== want.found_value)
          report("found_value", want.found_value, out_found_value);
        if (out_entry_count !== want.entry_count)
          report("entry_count", want.entry_count, out_entry_count);
        if (out_max_probe !== want.max_probe) report("max_probe", want.max_probe, out_max_probe);
      end
    end
  end

  always @(negedge clk) begin
    if (quiet) out_stall = 0;
    else if ($urandom_range(0, 99) < 4) out_stall = 1;
    else if ($urandom_range(0, 99) < 60) out_stall = 0;
  end

  task automatic send(row_t row);
    int gap, seen;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    cur_row = row;
    in_req_type = row.req;
    in_hash = row.hash;
    in_key_bytes = row.key;
    in_key_len = row.len;
    in_value = row.value;
    in_valid = 1;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
    in_valid = 0;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 0;
    wait (pending_results.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_key_limit(logic [3:0] lim);
    @(negedge clk);
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_paddr = {REG_MAX_KEY_LEN, 2'b00};
    cfg_pwdata = {28'($urandom_range(0, 32'h0FFF_FFFF)), lim};
    @(negedge clk);
    cfg_penable = 1;
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    key_limit = lim;
  endtask

  function automatic row_t mk(logic [1:0] req, logic [31:0] h, logic [63:0] k, logic [3:0] l,
                              logic [31:0] v, bit typed = 0, logic [2:0] st = ST_OK,
                              logic [31:0] fv = 0, int cnt = 0, int mp = 0);
    row_t r;
    r.req = req; r.hash = h; r.key = k; r.len = l; r.value = v; r.typed = typed;
    r.rsp.status = st; r.rsp.found_value = fv; r.rsp.entry_count = 11'(cnt);
    r.rsp.max_probe = 10'(mp);
    return r;
  endfunction

  row_t directed[$];
  logic [31:0] pool_hash [POOL];
  logic [63:0] pool_key  [POOL];
  logic [3:0]  pool_len  [POOL];

  initial begin
    row_t r;
    int p, op;
    logic [3:0] limits[5];
    limits = '{4'd8, 4'd0, 4'd15, 4'd4, 4'd8};
    rst_n = 0;
    in_valid = 0; in_req_type = REQ_FIND; in_hash = 0; in_key_bytes = 0;
    in_key_len = 0; in_value = 0; out_stall = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    cur_row.typed = 0;
    key_limit = MAX_KEY_LEN_RST;
    occupied = 0; max_dist = 0; errors = 0; accepted = 0; cycles = 0; quiet = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    directed = '{
      mk(REQ_FIND, 5, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0),
      mk(REQ_REMOVE, 5, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0),
      mk(REQ_INSERT, 5, '1, 8, '1, 1, ST_OK, 0, 1, 0),
      mk(REQ_INSERT, 6, 1, 9, 1, 1, ST_TOO_LONG, 0, 1, 0),
      mk(REQ_INSERT, 6, '1, 15, 1, 1, ST_TOO_LONG, 0, 1, 0),
      mk(REQ_FIND, 5, '1, 8, 0, 1, ST_OK, 32'hFFFF_FFFF, 1, 0),
      mk(REQ_INS_ABSENT, 5, '1, 8, 7, 1, ST_DUPLICATE, 0, 1, 0),
      mk(REQ_INSERT, 32'h405, 1, 1, 32'h1234, 0),
      mk(REQ_INSERT, 5, 2, 1, 32'h55, 0),
      mk(REQ_INSERT, 32'hFFFF_FFFF, '1, 3, 0, 0),
      mk(REQ_INSERT, 32'h3FF, 5, 2, 32'hA5A5_5A5A, 0),
      mk(REQ_INSERT, 5, '1, 8, 32'h77, 0),
      mk(REQ_FIND, 32'h405, 64'hFFFF_FFFF_FFFF_FF01, 1, 0, 0),
      mk(REQ_INS_ABSENT, 32'h405, 1, 2, 3, 0),
      mk(REQ_REMOVE, 5, '1, 8, 0, 0),
      mk(REQ_FIND, 5, 2, 1, 0, 0),
      mk(REQ_FIND, 5, '1, 8, 0, 0),
      mk(REQ_REMOVE, 32'h3FF, 5, 2, 0, 0),
      mk(REQ_INSERT, 7, '1, 0, 32'h8000_0001, 0),
      mk(REQ_FIND, 7, 0, 0, 0, 0),
      mk(REQ_REMOVE, 32'hFFFF_FFFF, 64'h00FF_FFFF, 3, 0, 0)
    };
    foreach (directed[i]) send(directed[i]);
    go_idle();

    for (int i = 0; i < POOL; i++) begin
      pool_hash[i] = {$urandom_range(0, 22'h3F_FFFF), 10'($urandom_range(0, 47))};
      pool_key[i] = {$urandom(), $urandom()};
      pool_len[i] = $urandom_range(0, 8);
    end

    foreach (limits[ph]) begin
      write_key_limit(limits[ph]);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 170; n++) begin
        op = $urandom_range(0, 99);
        r.req = (op < 28) ? REQ_INSERT : (op < 48) ? REQ_INS_ABSENT :
                (op < 75) ? REQ_FIND : REQ_REMOVE;
        r.typed = 0;
        r.value = $urandom();
        if ($urandom_range(0, 99) < 85) begin
          p = $urandom_range(0, POOL - 1);
          r.hash = pool_hash[p];
          r.len = pool_len[p];
          r.key = pool_key[p] & len_mask(r.len) | (~len_mask(r.len) & {$urandom(), $urandom()});
        end else begin
          r.hash = $urandom();
          r.len = $urandom_range(0, 8);
          r.key = {$urandom(), $urandom()};
        end
        send(r);
        if (n % 40 == 39) quiet = ($urandom_range(0, 3) == 0);
      end
      go_idle();
    end

    if (errors == 0) $display("[robin_hood_hash_table_core] OK");
    else $display("[robin_hood_hash_table_core] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rhh_pkg.sv
rtl/rhh_slot_ram.sv
rtl/robin_hood_hash_table_core.sv
rtl/rhh_checker.sv
test/testbench.sv
